@@ src/rfbx_pkg.sv @@
package rfbx_pkg;

    // Frame byte constants
    localparam logic [7:0] HEAD_BYTE  = 8'hAA;
    localparam logic [7:0] TAIL_BYTE  = 8'h55;
    localparam logic [7:0] REPLY_BYTE = 8'h00;
    localparam logic [3:0] NIB_MASK   = 4'hF;

    // Byte positions within a frame, counted from the 0xAA head byte
    localparam logic [3:0] POS_HEAD   = 4'd0;
    localparam logic [3:0] POS_LEN    = 4'd1;
    localparam logic [3:0] POS_CMD    = 4'd2;
    localparam logic [3:0] POS_ID0    = 4'd3;
    localparam logic [3:0] POS_ID1    = 4'd4;
    localparam logic [3:0] POS_ID2    = 4'd5;
    localparam logic [3:0] POS_ID3    = 4'd6;
    localparam logic [3:0] POS_BODY   = 4'd7;
    localparam logic [3:0] POS_CSUM   = 4'd8;
    localparam logic [3:0] POS_TAIL   = 4'd9;

    // Input item op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Kind of work handed from the front to the back
    typedef enum logic [1:0] {
        KIND_HEAD = 2'd0,   // header bytes, positions 0..7
        KIND_DATA = 2'd1,   // one payload byte at the body position
        KIND_ERR  = 2'd2    // stray payload, one flagged zero byte
    } kind_t;

    // One queued job: everything the back needs to emit its bytes
    typedef struct packed {
        kind_t       kind;
        logic        trailer;    // append checksum and 0x55
        logic [7:0]  csum;       // checksum used by the trailer
        logic [7:0]  frame_len;
        logic [7:0]  command;
        logic [15:0] command_id;
        logic [7:0]  body;       // byte at the body position
    } job_t;

endpackage

@@ src/radio_frame_builder_xor_top.sv @@
// Channel | Dir | Handshake           | Contents
// s_      | in  | s_tvalid / s_tready | tuser: op; tdata: len, command, command_id, data_byte
// m_      | out | m_tvalid / m_tready | tdata: out_byte; tlast: last; tuser: frame_end, error
//
// Bytes: a start item emits 8 output bytes, 10 when its length is zero; a
//   payload item emits 1 byte, 3 when it closes the frame; a stray payload 1.
//   The back's output register sends one byte per cycle while a job is queued and m_ does not stall.
// Path: an accepted item is written into the job queue, then its first byte into the output register.
// Reset: synchronous, active low; clears frame state, job queue and output valid.
// Stalls: a two-job queue lets the front keep taking items while m_ stalls, until the queue is full.
module radio_frame_builder_xor_top
    import rfbx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frame_len[7:0], command[15:8], command_id[31:16],
                                   // data_byte[39:32]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // frame_end[0], error[1]
);

    job_t push_job;
    job_t head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    rfbx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    rfbx_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    rfbx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/rfbx_front.sv @@
module rfbx_front
    import rfbx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  xor_reg, xor_next;

    logic        op;
    logic [7:0]  frame_len;
    logic [7:0]  command;
    logic [15:0] command_id;
    logic [7:0]  data_byte;
    logic [7:0]  head_xor;
    logic [7:0]  data_xor;
    logic        accept;

    // Field unpacking
    assign op         = s_tuser[0];
    assign frame_len  = s_tdata[7:0];
    assign command    = s_tdata[15:8];
    assign command_id = s_tdata[31:16];
    assign data_byte  = s_tdata[39:32];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // Checksum of a whole header, and running checksum after one payload byte
    assign head_xor = HEAD_BYTE ^ frame_len ^ command ^ REPLY_BYTE
                    ^ {4'h0, command_id[3:0] & NIB_MASK}
                    ^ {4'h0, command_id[7:4] & NIB_MASK}
                    ^ {4'h0, command_id[11:8] & NIB_MASK}
                    ^ {4'h0, command_id[15:12] & NIB_MASK};
    assign data_xor = xor_reg ^ data_byte;

    // Classify the item and advance the frame state
    always_comb begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        q_job.kind       = KIND_ERR;
        q_job.trailer    = 1'b0;
        q_job.csum       = 8'h00;
        q_job.frame_len  = frame_len;
        q_job.command    = command;
        q_job.command_id = command_id;
        q_job.body       = 8'h00;
        if (op == OP_START) begin
            q_job.kind = KIND_HEAD;
            q_job.body = REPLY_BYTE;
            if (frame_len == 8'h00) begin
                q_job.trailer   = 1'b1;
                q_job.csum      = head_xor;
                in_frame_next   = 1'b0;
                bytes_left_next = 8'h00;
                xor_next        = 8'h00;
            end else begin
                in_frame_next   = 1'b1;
                bytes_left_next = frame_len;
                xor_next        = head_xor;
            end
        end else if (in_frame_reg) begin
            q_job.kind = KIND_DATA;
            q_job.body = data_byte;
            if (bytes_left_reg == 8'h01) begin
                q_job.trailer   = 1'b1;
                q_job.csum      = data_xor;
                in_frame_next   = 1'b0;
                bytes_left_next = 8'h00;
                xor_next        = 8'h00;
            end else begin
                bytes_left_next = bytes_left_reg - 8'h01;
                xor_next        = data_xor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'h00;
            xor_reg        <= 8'h00;
        end else if (accept) begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
        end
    end

    // An open frame always expects at least one more payload byte
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> bytes_left_reg != 8'h00)
        else $error("open frame with no bytes left");

    a_closed_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (bytes_left_reg == 8'h00) && (xor_reg == 8'h00))
        else $error("closed frame holds stale state");

endmodule

@@ src/rfbx_fifo.sv @@
module rfbx_fifo
    import rfbx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign head_job = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("job queue underflow");

endmodule

@@ src/rfbx_back.sv @@
module rfbx_back
    import rfbx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    logic [3:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic [1:0] m_tuser_reg, m_tuser_next;

    logic [3:0] pos;
    logic [3:0] last_pos;
    logic       emit;
    logic       is_last;
    logic [7:0] byte_sel;

    // Header jobs start at the head byte, others at the body position
    assign pos      = (head_job.kind == KIND_HEAD) ? step_reg : step_reg + POS_BODY;
    assign last_pos = head_job.trailer ? POS_TAIL : POS_BODY;
    assign is_last  = pos == last_pos;
    assign emit     = !q_empty && (!m_tvalid_reg || m_tready);
    assign q_pop    = emit && is_last;

    // Byte select by frame position
    always_comb begin
        case (pos)
            POS_HEAD: byte_sel = HEAD_BYTE;
            POS_LEN:  byte_sel = head_job.frame_len;
            POS_CMD:  byte_sel = head_job.command;
            POS_ID0:  byte_sel = {4'h0, head_job.command_id[3:0] & NIB_MASK};
            POS_ID1:  byte_sel = {4'h0, head_job.command_id[7:4] & NIB_MASK};
            POS_ID2:  byte_sel = {4'h0, head_job.command_id[11:8] & NIB_MASK};
            POS_ID3:  byte_sel = {4'h0, head_job.command_id[15:12] & NIB_MASK};
            POS_BODY: byte_sel = head_job.body;
            POS_CSUM: byte_sel = head_job.csum;
            POS_TAIL: byte_sel = TAIL_BYTE;
            default:  byte_sel = 8'h00;
        endcase
    end

    // Step counter and output register
    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (emit) begin
            step_next     = is_last ? 4'd0 : step_reg + 4'd1;
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_sel;
            m_tlast_next  = is_last;
            m_tuser_next  = {head_job.kind == KIND_ERR, pos == POS_TAIL};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Closing byte and error byte both end their item
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == TAIL_BYTE))
        else $error("frame end not on the closing byte");

    a_err_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[0])
        else $error("malformed error byte");

endmodule

@@ tb/radio_frame_builder_xor_top_test.sv @@
`timescale 1ns / 100ps

module radio_frame_builder_xor_top_test;
    import rfbx_pkg::*;

    localparam int IDLE_LIMIT  = 1000;  // cycles with no item moving on either side
    localparam int SQUEEZE_AT  = 200;   // output count that triggers the long hold
    localparam int SQUEEZE_LEN = 300;   // length of the long hold, in cycles
    localparam int RANDOM_UPTO = 380;   // stop generating once this many items are queued

    // One input item as the sender sees it
    typedef struct packed {
        logic        op;
        logic [7:0]  frame_len;
        logic [7:0]  command;
        logic [15:0] command_id;
        logic [7:0]  data_byte;
    } frame_item_t;

    // One wire byte with its side flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       frame_end;
        logic       stray;
    } wire_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // frame_len[7:0], command[15:8], command_id[31:16],
                                  // data_byte[39:32]
    logic [0:0]  s_tuser  = '0;   // op[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte[7:0]
    logic        m_tlast;
    logic [1:0]  m_tuser;         // frame_end[0], error[1]

    frame_item_t pending_items[$];
    wire_byte_t  expected_bytes[$];

    // Predictor copy of the framer state
    logic        open_frame   = 1'b0;
    logic [7:0]  payload_left = '0;
    logic [7:0]  frame_xor    = '0;

    int          total_items    = 0;
    int          items_offered  = 0;
    int          items_accepted = 0;
    int          bytes_seen     = 0;
    int          error_count    = 0;
    int          idle_cycles    = 0;
    int          send_gap       = 0;
    int          recv_wait      = 0;
    int          recv_draw      = 0;
    int          hold_left      = 0;
    bit          squeezed       = 1'b0;
    bit          item_taken     = 1'b0;
    bit          byte_taken     = 1'b0;
    frame_item_t drive_item;
    wire_byte_t  got_byte;
    wire_byte_t  want_byte;

    radio_frame_builder_xor_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out the wire bytes one accepted item produces and queue them
    task automatic predict_frame_bytes(input logic op, input logic [7:0] len,
                                       input logic [7:0] cmd, input logic [15:0] id,
                                       input logic [7:0] data);
        logic [7:0] header [8];
        wire_byte_t burst[$];
        wire_byte_t fb;
        bit         close;
        close = 1'b0;
        if (op == OP_START) begin
            header[0] = HEAD_BYTE;
            header[1] = len;
            header[2] = cmd;
            header[3] = {4'h0, id[3:0]   & NIB_MASK};
            header[4] = {4'h0, id[7:4]   & NIB_MASK};
            header[5] = {4'h0, id[11:8]  & NIB_MASK};
            header[6] = {4'h0, id[15:12] & NIB_MASK};
            header[7] = REPLY_BYTE;
            frame_xor = '0;
            for (int i = 0; i < 8; i++) begin
                frame_xor   = frame_xor ^ header[i];
                fb          = '0;
                fb.out_byte = header[i];
                burst.push_back(fb);
            end
            open_frame   = 1'b1;
            payload_left = len;
            close        = (len == 8'd0);
        end else if (!open_frame) begin
            // payload with nothing open: one flagged zero byte, state untouched
            fb       = '0;
            fb.stray = 1'b1;
            burst.push_back(fb);
        end else begin
            frame_xor    = frame_xor ^ data;
            fb           = '0;
            fb.out_byte  = data;
            burst.push_back(fb);
            payload_left = payload_left - 8'd1;
            close        = (payload_left == 8'd0);
        end
        // checksum then closing byte
        if (close) begin
            fb           = '0;
            fb.out_byte  = frame_xor;
            burst.push_back(fb);
            fb           = '0;
            fb.out_byte  = TAIL_BYTE;
            fb.frame_end = 1'b1;
            burst.push_back(fb);
            open_frame   = 1'b0;
            payload_left = '0;
            frame_xor    = '0;
        end
        for (int i = 0; i < burst.size(); i++) begin
            fb      = burst[i];
            fb.last = (i == burst.size() - 1);
            expected_bytes.push_back(fb);
        end
    endtask

    function automatic frame_item_t random_item();
        frame_item_t r;
        r.op         = 1'($urandom);
        r.frame_len  = 8'($urandom);
        r.command    = 8'($urandom);
        r.command_id = 16'($urandom);
        r.data_byte  = 8'($urandom);
        return r;
    endfunction

    task automatic queue_start(input logic [7:0] len, input logic [7:0] cmd,
                               input logic [15:0] id);
        frame_item_t r;
        r            = random_item();
        r.op         = OP_START;
        r.frame_len  = len;
        r.command    = cmd;
        r.command_id = id;
        pending_items.push_back(r);
    endtask

    task automatic queue_payload(input logic [7:0] data);
        frame_item_t r;
        r           = random_item();
        r.op        = OP_DATA;
        r.data_byte = data;
        pending_items.push_back(r);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int pick;
        int len;
        int sent_len;

        // directed: stray payloads, zero length, close, abandon, long lengths
        queue_payload(8'h00);
        queue_payload(8'hFF);
        queue_start(8'd0, 8'h00, 16'h0000);
        queue_start(8'd0, 8'hFF, 16'hFFFF);
        queue_start(8'd1, 8'h5A, 16'h1234);
        queue_payload(8'hFF);
        queue_payload(8'h3C);
        queue_start(8'd3, 8'hC3, 16'hABCD);
        queue_payload(8'h00);
        queue_start(8'd2, 8'hA5, 16'hF00F);
        queue_payload(8'h80);
        queue_payload(8'h7F);
        queue_start(8'd255, 8'h01, 16'h8421);
        queue_payload(8'hAA);
        queue_payload(8'h55);
        queue_start(8'd128, 8'h80, 16'h7BDE);
        queue_payload(8'h01);
        queue_start(8'd0, 8'h7F, 16'h0000);
        queue_payload(8'h00);

        // random: mostly whole frames, some cut short, some stray payloads
        while (pending_items.size() < RANDOM_UPTO) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 3)) queue_payload(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    len = $urandom_range(16, 60);
                else if (pick < 15)
                    len = 0;
                else
                    len = $urandom_range(1, 8);
                sent_len = len;
                if (len > 0 && $urandom_range(0, 9) == 0)
                    sent_len = $urandom_range(0, len - 1);
                queue_start(8'(len), 8'($urandom), 16'($urandom));
                repeat (sent_len) queue_payload(8'($urandom));
            end
        end
        total_items = pending_items.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < total_items) @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("radio_frame_builder_xor_top_test: done, clean");
        else
            $display("radio_frame_builder_xor_top_test: done, errors");
        $finish;
    end

    // Sender: one item at a time, a random gap after each item, none in calm stretches
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !item_taken) begin
            // hold the offered item
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
            drive_item = pending_items.pop_front();
            s_tvalid   <= 1'b1;
            s_tuser    <= drive_item.op;
            s_tdata    <= {drive_item.data_byte, drive_item.command_id,
                           drive_item.command, drive_item.frame_len};
            send_gap   <= ((items_offered / 50) % 4 == 3) ? 0 : $urandom_range(0, 3);
            items_offered++;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall after each byte, one long hold to back up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (byte_taken && !squeezed && bytes_seen >= SQUEEZE_AT) begin
            m_tready  <= 1'b0;
            hold_left <= SQUEEZE_LEN;
            squeezed  <= 1'b1;
        end else if (byte_taken) begin
            recv_draw = ((bytes_seen / 60) % 3 == 1) ? 0 : $urandom_range(0, 3);
            m_tready  <= (recv_draw == 0);
            recv_wait <= (recv_draw == 0) ? 0 : recv_draw - 1;
        end else if (recv_wait > 0) begin
            m_tready  <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Prediction on accepted items, checking on accepted bytes, watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            item_taken <= 1'b0;
            byte_taken <= 1'b0;
        end else begin
            item_taken <= s_tvalid && s_tready;
            byte_taken <= m_tvalid && m_tready;

            if (s_tvalid && s_tready) begin
                predict_frame_bytes(s_tuser[0], s_tdata[7:0], s_tdata[15:8],
                                    s_tdata[31:16], s_tdata[39:32]);
                items_accepted++;
            end

            if (m_tvalid && m_tready) begin
                bytes_seen++;
                got_byte = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, got data %h last %b user %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    error_count++;
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (got_byte.out_byte !== want_byte.out_byte) begin
                        $display("%0t: out_byte expected %h got %h",
                                 $time, want_byte.out_byte, got_byte.out_byte);
                        error_count++;
                    end
                    if (got_byte.last !== want_byte.last) begin
                        $display("%0t: last expected %b got %b",
                                 $time, want_byte.last, got_byte.last);
                        error_count++;
                    end
                    if (got_byte.frame_end !== want_byte.frame_end) begin
                        $display("%0t: frame_end expected %b got %b",
                                 $time, want_byte.frame_end, got_byte.frame_end);
                        error_count++;
                    end
                    if (got_byte.stray !== want_byte.stray) begin
                        $display("%0t: error flag expected %b got %b",
                                 $time, want_byte.stray, got_byte.stray);
                        error_count++;
                    end
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            // nothing moving for too long: give up
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("radio_frame_builder_xor_top_test: done, errors");
                $finish;
            end
        end
    end

endmodule
